@@ hdl/assert_macros.svh @@
// Assertion macros shared by the admission unit.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/tpca_pkg.sv @@
// Package of the credit admission unit: status and opcode codes, command and status structs.
// Depends on nothing.
package tpca_pkg;
    localparam logic [2:0] OP_TRY     = 3'd0;
    localparam logic [2:0] OP_WAIT    = 3'd1;
    localparam logic [2:0] OP_RELEASE = 3'd2;
    localparam logic [2:0] OP_CANCEL  = 3'd3;
    localparam logic [2:0] OP_RESCAN  = 3'd4;

    localparam logic [2:0] ST_ADMITTED     = 3'd0;
    localparam logic [2:0] ST_QUEUED       = 3'd1;
    localparam logic [2:0] ST_REFUSED      = 3'd2;
    localparam logic [2:0] ST_CANCELLED    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd4;
    localparam logic [2:0] ST_OVER_RELEASE = 3'd5;
    localparam logic [2:0] ST_QUEUE_FULL   = 3'd6;
    localparam logic [2:0] ST_DONE         = 3'd7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture input item
        logic req_apply;  // try/wait decision and update
        logic rel_apply;  // release credits
        logic rel_reject; // report an over release
        logic srch_start; // begin cancel search
        logic srch_step;  // examine one entry
        logic drain_step; // admit one head entry
        logic shift_step; // move one entry down
    } cmd_t;

    // Status from the datapath
    typedef struct packed {
        logic srch_done;
        logic srch_found;
        logic drain_ok;   // a head entry fits
        logic shift_done;
    } sts_t;
endpackage

@@ hdl/tpca_datapath.sv @@
// Datapath: credit counters, two FIFOs in registers, search, drain and shift.
// Depends on tpca_pkg.
module tpca_datapath
    import tpca_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8,
    parameter int BYTE_BITS   = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BYTE_BITS-1:0] cap_bytes,
    input  logic [15:0]          cap_slots,
    input  logic [2:0]           in_op,
    input  logic [TAG_BITS-1:0]  in_tag,
    input  logic                 in_pri,
    input  logic [BYTE_BITS-1:0] in_bytes,
    input  logic [15:0]          in_slots,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic [2:0]           op_q,
    output logic                 rel_over,
    output logic [TAG_BITS-1:0]  res_tag,
    output logic [2:0]           res_status,
    output logic                 res_pri
);
    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
    localparam logic [BYTE_BITS-1:0] BMAX = '1;

    logic [TAG_BITS-1:0]  tags_reg  [2][QUEUE_DEPTH];
    logic [BYTE_BITS-1:0] bytes_reg [2][QUEUE_DEPTH];
    logic [15:0]          slots_reg [2][QUEUE_DEPTH];
    logic [CW-1:0] cnt_reg [2];
    logic [BYTE_BITS-1:0] ifb_reg;
    logic [15:0] ifs_reg;
    logic [2:0] op_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic pri_reg;
    logic [BYTE_BITS-1:0] b_reg;
    logic [15:0] s_reg;
    logic sq_reg;           // queue under search / shift
    logic [CW-1:0] idx_reg; // search / shift position

    assign op_q = op_reg;
    assign rel_over = (b_reg > ifb_reg) || (s_reg > ifs_reg);

    // Fit test against the two budgets
    function automatic logic fits_f(input logic [BYTE_BITS-1:0] b, input logic [15:0] s,
        input logic [BYTE_BITS-1:0] ib, input logic [15:0] is_,
        input logic [BYTE_BITS-1:0] cb, input logic [15:0] cs);
        logic ok;
        begin
            ok = 1'b1;
            if (cs != '0 && (is_ > cs || s > cs - is_)) ok = 1'b0;
            if (cb != '0) begin
                if (b > cb) begin
                    if (ib != '0) ok = 1'b0;
                end else if (ib > cb || b > cb - ib) ok = 1'b0;
            end
            return ok;
        end
    endfunction

    // Drain picks high queue, then low when high is empty
    logic dq;
    logic [BYTE_BITS-1:0] hb;
    logic [15:0] hs;
    assign dq = (cnt_reg[1] != '0);
    assign hb = bytes_reg[dq][0];
    assign hs = slots_reg[dq][0];
    logic req_ok;
    assign req_ok = fits_f(b_reg, s_reg, ifb_reg, ifs_reg, cap_bytes, cap_slots)
                    && cnt_reg[1] == '0 && (pri_reg || cnt_reg[0] == '0);
    logic head_fits;
    assign head_fits = fits_f(hb, hs, ifb_reg, ifs_reg, cap_bytes, cap_slots);
    // A low entry drains only when the high queue is empty
    assign sts.drain_ok = (dq || cnt_reg[0] != '0) && head_fits;

    logic [IW-1:0] ix;
    assign ix = idx_reg[IW-1:0];
    logic srch_hit;
    assign srch_hit = (idx_reg < cnt_reg[sq_reg]) && tags_reg[sq_reg][ix] == tag_reg;
    assign sts.srch_found = srch_hit;
    assign sts.srch_done = srch_hit || (!sq_reg && idx_reg >= cnt_reg[0]);
    assign sts.shift_done = (idx_reg + CW'(1)) >= cnt_reg[sq_reg];

    // Saturating reserve
    function automatic logic [BYTE_BITS-1:0] addb(input logic [BYTE_BITS-1:0] a,
        input logic [BYTE_BITS-1:0] b);
        begin
            return (b > BMAX - a) ? BMAX : a + b;
        end
    endfunction
    function automatic logic [15:0] adds(input logic [15:0] a, input logic [15:0] b);
        begin
            return (b > 16'hFFFF - a) ? 16'hFFFF : a + b;
        end
    endfunction

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg <= in_tag;
            pri_reg <= in_pri;
            b_reg <= in_bytes;
            s_reg <= in_slots;
        end
        if (cmd.req_apply && !req_ok && op_reg == OP_WAIT && cnt_reg[pri_reg] < FULL)
        begin
            tags_reg[pri_reg][cnt_reg[pri_reg][IW-1:0]] <= tag_reg;
            bytes_reg[pri_reg][cnt_reg[pri_reg][IW-1:0]] <= b_reg;
            slots_reg[pri_reg][cnt_reg[pri_reg][IW-1:0]] <= s_reg;
        end
        // Shift one entry down (used for both cancel and drain removal)
        if (cmd.shift_step && !sts.shift_done)
        begin
            tags_reg[sq_reg][ix] <= tags_reg[sq_reg][IW'(idx_reg + CW'(1))];
            bytes_reg[sq_reg][ix] <= bytes_reg[sq_reg][IW'(idx_reg + CW'(1))];
            slots_reg[sq_reg][ix] <= slots_reg[sq_reg][IW'(idx_reg + CW'(1))];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_TRY;
            ifb_reg <= '0;
            ifs_reg <= '0;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            sq_reg <= 1'b1;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.load) op_reg <= in_op;
            if (cmd.req_apply)
            begin
                if (req_ok)
                begin
                    ifb_reg <= addb(ifb_reg, b_reg);
                    ifs_reg <= adds(ifs_reg, s_reg);
                end
                else if (op_reg == OP_WAIT && cnt_reg[pri_reg] < FULL)
                    cnt_reg[pri_reg] <= cnt_reg[pri_reg] + CW'(1);
            end
            if (cmd.rel_apply)
            begin
                ifb_reg <= ifb_reg - b_reg;
                ifs_reg <= ifs_reg - s_reg;
            end
            if (cmd.srch_start)
            begin
                sq_reg <= 1'b1;
                idx_reg <= '0;
            end
            if (cmd.srch_step && !srch_hit)
            begin
                if (idx_reg >= cnt_reg[sq_reg])
                begin
                    sq_reg <= 1'b0;
                    idx_reg <= '0;
                end
                else
                    idx_reg <= idx_reg + CW'(1);
            end
            // Admit the head; the shift then removes it
            if (cmd.drain_step)
            begin
                ifb_reg <= addb(ifb_reg, hb);
                ifs_reg <= adds(ifs_reg, hs);
                sq_reg <= dq;
                idx_reg <= '0;
            end
            if (cmd.shift_step)
            begin
                if (sts.shift_done)
                    cnt_reg[sq_reg] <= cnt_reg[sq_reg] - CW'(1);
                else
                    idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    // Result of the current step
    always_comb
    begin
        res_tag = tag_reg;
        res_pri = pri_reg;
        res_status = ST_DONE;
        if (cmd.req_apply)
        begin
            if (req_ok) res_status = ST_ADMITTED;
            else if (op_reg == OP_TRY) res_status = ST_REFUSED;
            else if (cnt_reg[pri_reg] < FULL) res_status = ST_QUEUED;
            else res_status = ST_QUEUE_FULL;
        end
        else if (cmd.srch_step)
        begin
            res_status = srch_hit ? ST_CANCELLED : ST_NOT_FOUND;
            if (srch_hit) res_pri = sq_reg;
        end
        else if (cmd.drain_step)
        begin
            res_status = ST_ADMITTED;
            res_tag = tags_reg[dq][0];
            res_pri = dq;
        end
        else if (cmd.rel_reject)
            res_status = ST_OVER_RELEASE;
    end
endmodule

@@ hdl/tpca_ctrl.sv @@
// Controller state machine of the admission unit; drives the datapath steps.
// Depends on tpca_pkg.
module tpca_ctrl
    import tpca_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op_q,
    input  logic       rel_over,
    input  sts_t       sts,
    input  logic       out_free,
    output cmd_t       cmd,
    output logic       emit,
    output logic       emit_last
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DEC   = 7'b0000010,
        S_SRCH  = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_CSH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        emit = 1'b0;
        emit_last = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid) state_next = S_DEC;
            end
            S_DEC:
            begin
                if (out_free)
                begin
                    case (op_q) inside
                        OP_TRY, OP_WAIT:
                        begin
                            cmd.req_apply = 1'b1;
                            emit = 1'b1;
                            emit_last = 1'b1;
                            state_next = S_IDLE;
                        end
                        OP_RELEASE:
                        begin
                            if (rel_over)
                            begin
                                cmd.rel_reject = 1'b1;
                                emit = 1'b1;
                                emit_last = 1'b1;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                cmd.rel_apply = 1'b1;
                                state_next = S_DRAIN;
                            end
                        end
                        OP_CANCEL:
                        begin
                            cmd.srch_start = 1'b1;
                            state_next = S_SRCH;
                        end
                        OP_RESCAN: state_next = S_DRAIN;
                        default:
                        begin
                            emit = 1'b1;
                            emit_last = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (!sts.srch_done) cmd.srch_step = 1'b1;
                else if (out_free)
                begin
                    cmd.srch_step = 1'b1;
                    emit = 1'b1;
                    emit_last = !sts.srch_found;
                    state_next = sts.srch_found ? S_CSH : S_IDLE;
                end
            end
            S_CSH:
            begin
                cmd.shift_step = 1'b1;
                if (sts.shift_done) state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!sts.drain_ok) state_next = S_DONE;
                else if (out_free)
                begin
                    cmd.drain_step = 1'b1;
                    emit = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (sts.shift_done) state_next = S_DRAIN;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    emit_last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule

@@ hdl/two_priority_credit_admission_unit.sv @@
// Top level of the two-priority credit admission unit.
// Depends on tpca_pkg, tpca_ctrl, tpca_datapath and assert_macros.svh.
//
// Usage: requests enter on the s_axis channel, one at a time; each yields one
// or more result transfers on m_axis, the final one with m_axis_tlast high.
// Capacities are written through cfg_we/cfg_index/cfg_data while idle.
// Sequence: a try/wait request is captured in S_IDLE and decided in S_DEC,
// where its result is registered once the output is free; the unit then
// returns to S_IDLE for the next request. A valid release or a rescan goes
// on to S_DRAIN and ends in S_DONE; each admitted waiter adds an admit step
// in S_DRAIN and a register shift of its queue in S_SHIFT, and a cancel first
// searches entry by entry in S_SRCH and shifts out the entry it finds in S_CSH.
// The queue shift sets the worst case: both full queues drained after a cancel.
// s_axis_tready is high only while the unit is idle. The single output
// register holds a result until taken; a stalled receiver stalls the unit.
// Reset clears credits in flight and both queue counts; capacities reset to
// zero (unlimited).
`include "assert_macros.svh"
module two_priority_credit_admission_unit
    import tpca_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 8,
    parameter int BYTE_BITS   = 48
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_index,
    input  logic [BYTE_BITS-1:0] cfg_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // opcode, tag, priority_req, request_bytes, request_slots; zero fill to bytes
    input  logic [((3+TAG_BITS+1+BYTE_BITS+16+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // tag_res, status, priority_res; zero fill to bytes
    output logic [((TAG_BITS+4+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    localparam int OW = ((TAG_BITS+4+7)/8)*8;
    localparam int IL = 3 + TAG_BITS + 1;

    logic [BYTE_BITS-1:0] capb_reg;
    logic [15:0] caps_reg;
    cmd_t cmd;
    sts_t sts;
    logic [2:0] op_q, res_status;
    logic rel_over, res_pri, emit, emit_last;
    logic [TAG_BITS-1:0] res_tag;
    logic ov_reg, last_reg;
    logic [OW-1:0] od_reg;
    logic out_free;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capb_reg <= '0;
            caps_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (!cfg_index) capb_reg <= cfg_data;
            else caps_reg <= cfg_data[15:0];
        end
    end

    assign out_free = !ov_reg || m_axis_tready;

    tpca_ctrl u_ctrl (
        .clk, .rst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op_q, .rel_over, .sts, .out_free, .cmd, .emit, .emit_last
    );

    tpca_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS),
        .BYTE_BITS(BYTE_BITS)) u_dp (
        .clk, .rst_n, .cap_bytes(capb_reg), .cap_slots(caps_reg),
        .in_op(s_axis_tdata[2:0]), .in_tag(s_axis_tdata[3+TAG_BITS-1:3]),
        .in_pri(s_axis_tdata[3+TAG_BITS]),
        .in_bytes(s_axis_tdata[IL+BYTE_BITS-1:IL]),
        .in_slots(s_axis_tdata[IL+BYTE_BITS+15:IL+BYTE_BITS]),
        .cmd, .sts, .op_q, .rel_over, .res_tag, .res_status, .res_pri
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            last_reg <= 1'b0;
            od_reg <= '0;
        end
        else if (emit)
        begin
            ov_reg <= 1'b1;
            last_reg <= emit_last;
            od_reg <= OW'({res_pri, res_status, res_tag});
        end
        else if (m_axis_tready) ov_reg <= 1'b0;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = od_reg;
    assign m_axis_tlast = last_reg;

    `ASSERT_IMPLY(a_emit_free, clk, rst_n, emit, out_free, "emit into full register")
    `ASSERT_NEXT(a_emit_valid, clk, rst_n, emit, m_axis_tvalid, "emitted result missing")
    `ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, s_axis_tready, !cmd.drain_step,
        "drain while idle")
endmodule

@@ verif/two_priority_credit_admission_unit_test.sv @@
// Self-checking testbench for the two-priority credit admission unit.
// Depends on tpca_pkg and the two_priority_credit_admission_unit top level.
`timescale 1ns / 100ps

module two_priority_credit_admission_unit_test;
    import tpca_pkg::*;

    localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
    localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
    localparam logic [63:0] BYTE_MAX     = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] SLOT_MAX     = 64'hFFFF;
    localparam int          DEPTH        = 16;
    localparam int          SETTLE       = 2 * DEPTH * (DEPTH + 1) + 20;
    localparam int          RAND_ITEMS   = 64;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  op;
        logic [7:0]  tag;
        logic        pr;
        logic [47:0] nbytes;
        logic [15:0] nslots;
        logic        chk;
        logic [2:0]  st;
    } row_t;

    typedef struct {
        logic [7:0] tag;
        logic [2:0] st;
        logic       pr;
        logic       last;
    } admit_result_t;

    typedef struct {
        logic [7:0]  tag;
        logic [47:0] nbytes;
        logic [15:0] nslots;
    } waiter_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [47:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Predictor state
    logic [63:0]   cap_bytes;
    logic [63:0]   cap_slots;
    logic [63:0]   held_bytes;
    logic [63:0]   held_slots;
    waiter_t       wait_q [2][$];
    admit_result_t pending_results [$];

    int send_gap;
    int recv_stall;
    int n_errors;
    int n_items;
    int n_results;

    row_t directed_rows [24] = '{
        '{ROW_ITEM, OP_TRY,       8'd1,   1'b0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, ST_ADMITTED},
        '{ROW_ITEM, OP_RELEASE,   8'd2,   1'b1, 48'd0,   16'd0,    1'b1, ST_DONE},
        '{ROW_ITEM, OP_RELEASE,   8'd3,   1'b0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1, ST_DONE},
        '{ROW_ITEM, OP_RELEASE,   8'd4,   1'b0, 48'd1,   16'd0,    1'b1, ST_OVER_RELEASE},
        '{ROW_ITEM, OP_CANCEL,    8'd5,   1'b1, 48'd0,   16'd0,    1'b1, ST_NOT_FOUND},
        '{ROW_ITEM, OP_RESCAN,    8'd6,   1'b0, 48'd0,   16'd0,    1'b1, ST_DONE},
        '{ROW_ITEM, OP_UNUSED_LO, 8'd7,   1'b0, 48'd0,   16'd0,    1'b1, ST_DONE},
        '{ROW_ITEM, OP_UNUSED_HI, 8'd255, 1'b1, 48'd0,   16'd0,    1'b1, ST_DONE},
        '{ROW_CFG,  OP_TRY,       8'd0,   1'b0, 48'd100, 16'd4,    1'b0, ST_DONE},
        '{ROW_ITEM, OP_WAIT,      8'd10,  1'b1, 48'd60,  16'd1,    1'b1, ST_ADMITTED},
        '{ROW_ITEM, OP_WAIT,      8'd11,  1'b0, 48'd60,  16'd1,    1'b1, ST_QUEUED},
        '{ROW_ITEM, OP_WAIT,      8'd12,  1'b1, 48'd50,  16'd1,    1'b1, ST_QUEUED},
        '{ROW_ITEM, OP_TRY,       8'd13,  1'b0, 48'd1,   16'd0,    1'b1, ST_REFUSED},
        '{ROW_ITEM, OP_TRY,       8'd14,  1'b1, 48'd200, 16'd0,    1'b1, ST_REFUSED},
        '{ROW_ITEM, OP_WAIT,      8'd15,  1'b1, 48'd200, 16'd0,    1'b1, ST_QUEUED},
        '{ROW_ITEM, OP_CANCEL,    8'd11,  1'b1, 48'd0,   16'd0,    1'b0, ST_DONE},
        '{ROW_ITEM, OP_RELEASE,   8'd10,  1'b1, 48'd60,  16'd1,    1'b0, ST_DONE},
        '{ROW_ITEM, OP_RELEASE,   8'd16,  1'b0, 48'd50,  16'd1,    1'b0, ST_DONE},
        '{ROW_ITEM, OP_WAIT,      8'd17,  1'b0, 48'd0,   16'd4,    1'b0, ST_DONE},
        '{ROW_ITEM, OP_WAIT,      8'd18,  1'b0, 48'd0,   16'd1,    1'b0, ST_DONE},
        '{ROW_ITEM, OP_RESCAN,    8'd19,  1'b1, 48'd0,   16'd0,    1'b0, ST_DONE},
        '{ROW_CFG,  OP_TRY,       8'd0,   1'b0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, ST_DONE},
        '{ROW_ITEM, OP_TRY,       8'd20,  1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, ST_DONE},
        '{ROW_ITEM, OP_RELEASE,   8'd21,  1'b0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b0, ST_DONE}
    };

    two_priority_credit_admission_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Credit check: both budgets, zero capacity meaning unlimited
    function automatic bit credits_fit(logic [63:0] nb, logic [63:0] ns);
        if (cap_slots != 0 && (held_slots > cap_slots || ns > cap_slots - held_slots))
            return 1'b0;
        if (cap_bytes == 0)
            return 1'b1;
        if (nb > cap_bytes)
            return held_bytes == 0;
        return held_bytes <= cap_bytes && nb <= cap_bytes - held_bytes;
    endfunction

    // Take credits, saturating at the field maximum
    function automatic void take_credits(logic [63:0] nb, logic [63:0] ns);
        held_bytes = (nb > BYTE_MAX - held_bytes) ? BYTE_MAX : held_bytes + nb;
        held_slots = (ns > SLOT_MAX - held_slots) ? SLOT_MAX : held_slots + ns;
    endfunction

    function automatic void post_result(logic [7:0] tag, logic [2:0] st, logic pr);
        pending_results.push_back('{tag, st, pr, 1'b0});
    endfunction

    // Admit heads of one queue while they fit
    function automatic void admit_heads(int p);
        while (wait_q[p].size() > 0 && credits_fit(wait_q[p][0].nbytes, wait_q[p][0].nslots))
        begin
            take_credits(wait_q[p][0].nbytes, wait_q[p][0].nslots);
            post_result(wait_q[p][0].tag, ST_ADMITTED, p[0]);
            void'(wait_q[p].pop_front());
        end
    endfunction

    function automatic void drain_queues();
        admit_heads(1);
        if (wait_q[1].size() == 0)
            admit_heads(0);
    endfunction

    // Predict all results of one request; return the status of the first
    function automatic logic [2:0] predict_admission(logic [2:0] op, logic [7:0] tag,
                                                     logic pr, logic [47:0] nb,
                                                     logic [15:0] ns);
        int first;
        bit found;
        first = pending_results.size();
        found = 1'b0;
        if (op == OP_TRY || op == OP_WAIT)
        begin
            if (credits_fit(nb, ns) && wait_q[1].size() == 0 &&
                (pr || wait_q[0].size() == 0))
            begin
                take_credits(nb, ns);
                post_result(tag, ST_ADMITTED, pr);
            end
            else if (op == OP_TRY)
                post_result(tag, ST_REFUSED, pr);
            else if (wait_q[pr].size() >= DEPTH)
                post_result(tag, ST_QUEUE_FULL, pr);
            else
            begin
                wait_q[pr].push_back('{tag, nb, ns});
                post_result(tag, ST_QUEUED, pr);
            end
        end
        else if (op == OP_RELEASE)
        begin
            if (nb > held_bytes || ns > held_slots)
                post_result(tag, ST_OVER_RELEASE, pr);
            else
            begin
                held_bytes = held_bytes - nb;
                held_slots = held_slots - ns;
                drain_queues();
                post_result(tag, ST_DONE, pr);
            end
        end
        else if (op == OP_CANCEL)
        begin
            for (int p = 1; p >= 0 && !found; p--)
                for (int i = 0; i < wait_q[p].size() && !found; i++)
                    if (wait_q[p][i].tag == tag)
                    begin
                        wait_q[p].delete(i);
                        post_result(tag, ST_CANCELLED, p[0]);
                        found = 1'b1;
                    end
            if (found)
            begin
                drain_queues();
                post_result(tag, ST_DONE, pr);
            end
            else
                post_result(tag, ST_NOT_FOUND, pr);
        end
        else if (op == OP_RESCAN)
        begin
            drain_queues();
            post_result(tag, ST_DONE, pr);
        end
        else
            post_result(tag, ST_DONE, pr);
        pending_results[pending_results.size() - 1].last = 1'b1;
        return pending_results[first].st;
    endfunction

    // Send one request; entered and left at a rising edge
    task automatic send_request(logic [2:0] op, logic [7:0] tag, logic pr,
                                logic [47:0] nb, logic [15:0] ns,
                                logic chk, logic [2:0] chk_st);
        logic [2:0] first_st;
        while ($urandom_range(99) < send_gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, ns, nb, pr, tag, op};
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
            begin
                first_st = predict_admission(op, tag, pr, nb, ns);
                if (chk && first_st !== chk_st)
                begin
                    $display("%0t: table row status expected %0d, predicted %0d",
                             $time, chk_st, first_st);
                    n_errors++;
                end
                n_items++;
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    endtask

    // Write both capacities once the unit has gone quiet
    task automatic write_capacity(logic [47:0] nb, logic [15:0] ns);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= 1'b0;
        cfg_data  <= nb;
        @(posedge clk);
        cap_bytes = nb;
        cfg_index <= 1'b1;
        cfg_data  <= {32'b0, ns};
        @(posedge clk);
        cap_slots = ns;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom} & BYTE_MAX;
    endfunction

    // One random request, weighted toward sequences that exercise the queues
    task automatic send_random();
        int r;
        int pick;
        logic [2:0]  op;
        logic [7:0]  tag;
        logic        pr;
        logic [63:0] nb;
        logic [63:0] ns;
        r   = $urandom_range(99);
        tag = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
        pr  = 1'($urandom);
        nb  = $urandom_range(cap_bytes != 0 && cap_bytes < 400 ? cap_bytes : 300);
        ns  = $urandom_range(3);
        if ($urandom_range(19) == 0)
            nb = rand_wide();
        else if (cap_bytes != 0 && $urandom_range(9) == 0)
            nb = cap_bytes + $urandom_range(50);
        if ($urandom_range(19) == 0)
            ns = $urandom & SLOT_MAX;
        if (r < 38)
            op = OP_WAIT;
        else if (r < 52)
            op = OP_TRY;
        else if (r < 74)
        begin
            op = OP_RELEASE;
            if ($urandom_range(6) != 0)
            begin
                nb = (held_bytes == 0) ? 0 : {$urandom, $urandom} % (held_bytes + 1);
                ns = (held_slots == 0) ? 0 : $urandom % (held_slots + 1);
            end
        end
        else if (r < 87)
        begin
            op = OP_CANCEL;
            pick = $urandom_range(wait_q[0].size() + wait_q[1].size());
            if (pick < wait_q[1].size())
                tag = wait_q[1][pick].tag;
            else if (pick - wait_q[1].size() < wait_q[0].size())
                tag = wait_q[0][pick - wait_q[1].size()].tag;
        end
        else if (r < 95)
            op = OP_RESCAN;
        else
            op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        send_request(op, tag, pr, nb[47:0], ns[15:0], 1'b0, ST_DONE);
    endtask

    // Receiver stalls per phase
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Compare each result transfer with the oldest expectation
    always @(negedge clk)
    begin
        admit_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result tag %0d status %0d", $time,
                         m_axis_tdata[7:0], m_axis_tdata[10:8]);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.tag)
                begin
                    $display("%0t: tag_res expected %0d, actual %0d", $time,
                             want.tag, m_axis_tdata[7:0]);
                    n_errors++;
                end
                if (m_axis_tdata[10:8] !== want.st)
                begin
                    $display("%0t: status expected %0d, actual %0d", $time,
                             want.st, m_axis_tdata[10:8]);
                    n_errors++;
                end
                if (m_axis_tdata[11] !== want.pr)
                begin
                    $display("%0t: priority_res expected %0d, actual %0d", $time,
                             want.pr, m_axis_tdata[11]);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last expected %0d, actual %0d", $time,
                             want.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus and final verdict
    initial
    begin
        int stalls [4][2];
        logic [47:0] phase_bytes [4];
        logic [15:0] phase_slots [4];
        stalls = '{'{0, 0}, '{59, 0}, '{0, 59}, '{26, 26}};
        phase_bytes = '{48'd0, 48'd0, 48'd0, 48'd0};
        phase_slots = '{16'd0, 16'd0, 16'd0, 16'd0};
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= 1'b0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        cap_bytes  = 0;
        cap_slots  = 0;
        held_bytes = 0;
        held_slots = 0;
        send_gap   = 0;
        recv_stall = 0;
        n_errors   = 0;
        n_items    = 0;
        n_results  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_capacity(directed_rows[i].nbytes, directed_rows[i].nslots);
            else
                send_request(directed_rows[i].op, directed_rows[i].tag,
                             directed_rows[i].pr, directed_rows[i].nbytes,
                             directed_rows[i].nslots, directed_rows[i].chk,
                             directed_rows[i].st);
        end

        // Random phases, each under its own budget and idle pattern
        phase_bytes[0] = 48'($urandom_range(50, 400));
        phase_slots[0] = 16'($urandom_range(3, 6));
        phase_bytes[1] = 48'd0;
        phase_slots[1] = 16'd3;
        phase_bytes[2] = 48'($urandom_range(100, 1000));
        phase_slots[2] = 16'd0;
        phase_bytes[3] = 48'($urandom_range(50, 300));
        phase_slots[3] = 16'd1;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_capacity(phase_bytes[ph], phase_slots[ph]);
            send_gap   = stalls[ph][0];
            recv_stall = stalls[ph][1];
            repeat (RAND_ITEMS) send_random();
        end

        // Let the queues empty out
        write_capacity(48'd0, 16'd0);
        send_gap   = 0;
        recv_stall = 0;
        send_request(OP_RESCAN, 8'd0, 1'b1, 48'd0, 16'd0, 1'b0, ST_DONE);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d requests over four idle phases and several budgets;", n_items);
        $display("checked %0d result transfers against the predictor.", n_results);
        if (n_errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
